FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

// Check prop at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");

`endif

FILE: sv/rfrcc_pkg.sv
// ---------------------------------------------------------------------------
// rfrcc_pkg
// Types, constants and the CRC-16/MODBUS byte update for the frame receiver.
// ---------------------------------------------------------------------------
package rfrcc_pkg;

  localparam int BUFFER_DEPTH_DEF = 256;

  localparam logic [15:0] GAP_RESET = 16'd4;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam int          MIN_FRAME = 4;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_OK    = 2'd1,
    ST_CRC   = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/rfrcc_store.sv
// ---------------------------------------------------------------------------
// rfrcc_store
// Receive byte store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rfrcc_store #(
  parameter int DEPTH = rfrcc_pkg::BUFFER_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/rtu_frame_receiver_crc_check_unit.sv
// ---------------------------------------------------------------------------
// rtu_frame_receiver_crc_check_unit
// Modbus RTU frame receiver: byte store, silence timer and running CRC check.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | req_type, rx_byte, read_index
//   out     | output    | out_valid/out_stall| frame_status, frame_length,
//           |           |                    | read_data
//   cfg     | input     | cfg_wr_en          | cfg_wr_data (gap_ticks)
//
// One transfer per cycle in while in_stall is low; each result is held in the
// stage-A register and the registered read port of the byte store, then in the
// output register. Synchronous reset clears the pointer, silence count, CRC,
// delay line and valid flags; store contents stay undefined. A stalled
// output holds one result and one more in flight, then stalls the input.
// ---------------------------------------------------------------------------
module rtu_frame_receiver_crc_check_unit #(
  parameter int BUFFER_DEPTH = rfrcc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic [8:0]  out_frame_length,
  output logic [7:0]  out_read_data
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int WPW = $clog2(BUFFER_DEPTH + 1);

  logic [15:0]    gap_r;
  logic [WPW-1:0] wp_r, wp_nxt;
  logic [15:0]    silence_r, silence_nxt;
  logic [15:0]    crc_r, crc_nxt;
  logic [15:0]    held_r, held_nxt;

  logic           a_valid_r;
  logic [1:0]     a_status_r, a_status_nxt;
  logic [8:0]     a_length_r, a_length_nxt;
  logic           a_rd_r, a_rd_nxt;

  logic           out_valid_r;
  logic [1:0]     out_status_r;
  logic [8:0]     out_length_r;
  logic [7:0]     out_data_r;

  logic           accept;
  logic           advance;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;
  logic [WPW-1:0] eff_wp;
  logic [15:0]    eff_crc;
  logic [15:0]    eff_held;
  logic [AW+7:0]  idx_ext;
  logic [WPW+8:0] len_ext;
  logic           idx_in_range;
  rfrcc_pkg::req_t req;

  assign req     = rfrcc_pkg::req_t'(in_req_type);
  assign advance = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && out_valid_r && out_stall;
  assign accept  = in_valid && !in_stall;

  assign idx_ext      = {{AW{1'b0}}, in_read_index};
  assign rd_addr      = idx_ext[AW-1:0];
  assign idx_in_range = int'(in_read_index) < BUFFER_DEPTH;
  assign len_ext      = {9'd0, wp_r};

  always_comb begin
    wp_nxt       = wp_r;
    silence_nxt  = silence_r;
    crc_nxt      = crc_r;
    held_nxt     = held_r;
    a_status_nxt = rfrcc_pkg::ST_NONE;
    a_length_nxt = 9'd0;
    a_rd_nxt     = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    eff_wp       = wp_r;
    eff_crc      = crc_r;
    eff_held     = held_r;
    if (wp_r == WPW'(BUFFER_DEPTH)) begin
      eff_wp   = '0;
      eff_crc  = rfrcc_pkg::CRC_INIT;
      eff_held = 16'd0;
    end
    wr_addr = eff_wp[AW-1:0];
    unique case (req)
      rfrcc_pkg::REQ_BYTE: begin
        wr_en = accept;
        if (eff_wp >= WPW'(2)) begin
          crc_nxt = rfrcc_pkg::crc_feed(eff_crc, eff_held[15:8]);
        end else begin
          crc_nxt = eff_crc;
        end
        held_nxt    = {eff_held[7:0], in_rx_byte};
        wp_nxt      = eff_wp + WPW'(1);
        silence_nxt = 16'd0;
      end
      rfrcc_pkg::REQ_TICK: begin
        silence_nxt = silence_r + 16'd1;
        if (silence_nxt >= gap_r) begin
          if (wp_r == '0) begin
            a_status_nxt = rfrcc_pkg::ST_NONE;
          end else if (wp_r < WPW'(rfrcc_pkg::MIN_FRAME)) begin
            a_status_nxt = rfrcc_pkg::ST_SHORT;
          end else if (held_r[15:8] == crc_r[7:0] && held_r[7:0] == crc_r[15:8]) begin
            a_status_nxt = rfrcc_pkg::ST_OK;
            a_length_nxt = len_ext[8:0];
          end else begin
            a_status_nxt = rfrcc_pkg::ST_CRC;
          end
          wp_nxt      = '0;
          silence_nxt = 16'd0;
          crc_nxt     = rfrcc_pkg::CRC_INIT;
          held_nxt    = 16'd0;
        end
      end
      rfrcc_pkg::REQ_READ: begin
        rd_en    = accept;
        a_rd_nxt = idx_in_range;
      end
      rfrcc_pkg::REQ_NONE: begin
        a_rd_nxt = 1'b0;
      end
      default: begin
        a_rd_nxt = 1'b0;
      end
    endcase
  end

  rfrcc_store #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r     <= rfrcc_pkg::GAP_RESET;
      wp_r      <= '0;
      silence_r <= 16'd0;
      crc_r     <= rfrcc_pkg::CRC_INIT;
      held_r    <= 16'd0;
    end else begin
      if (cfg_wr_en) begin
        gap_r <= cfg_wr_data;
      end
      if (accept) begin
        wp_r      <= wp_nxt;
        silence_r <= silence_nxt;
        crc_r     <= crc_nxt;
        held_r    <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (advance) begin
        a_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_status_r <= a_status_nxt;
      a_length_r <= a_length_nxt;
      a_rd_r     <= a_rd_nxt;
    end
    if (advance) begin
      out_status_r <= a_status_r;
      out_length_r <= a_length_r;
      out_data_r   <= a_rd_r ? rd_data : 8'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = out_status_r;
  assign out_frame_length = out_length_r;
  assign out_read_data    = out_data_r;

endmodule

FILE: sv/rfrcc_checker.sv
// ---------------------------------------------------------------------------
// rfrcc_checker
// Port-level checks on the frame receiver, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rfrcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_frame_status,
  input logic [8:0] out_frame_length,
  input logic [7:0] out_read_data
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_frame_status) && $stable(out_frame_length) && $stable(out_read_data))

  `ASSERT_CLK(a_len_only_ok, clk, rst_n, out_valid && out_frame_status != rfrcc_pkg::ST_OK |-> out_frame_length == 9'd0)

  `ASSERT_CLK(a_read_no_status, clk, rst_n, out_valid && out_read_data != 8'd0 |-> out_frame_status == rfrcc_pkg::ST_NONE)

  `ASSERT_CLK(a_no_stall_free, clk, rst_n, !out_stall |-> !in_stall)

  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid)

endmodule

bind rtu_frame_receiver_crc_check_unit rfrcc_checker u_rfrcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_status (out_frame_status),
  .out_frame_length (out_frame_length),
  .out_read_data    (out_read_data)
);
